// ===== design/flpc_pkg.sv =====
package flpc_pkg;

  // Field and register widths
  localparam int DATA_W          = 32;
  localparam int HIST_W          = 16;
  localparam int COEF_W          = 16;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int REG_W           = 5;
  localparam int NUM_COEFS       = 16;
  localparam int COEFS_PER_GROUP = CFG_W / COEF_W;
  localparam int NUM_GROUPS      = NUM_COEFS / COEFS_PER_GROUP;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_GROUP_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_GROUP_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_GROUP_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_GROUP_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR_ORDER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_SHIFT     = 3'd5;

  // Order after reset
  localparam logic [REG_W-1:0] ORDER_RESET = 5'd2;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic clear;       // zero partial sum, load static coefficient
    logic shift_coef;  // move coefficients one cell toward the head
    logic push;        // push a sample into history and partial sums
  } cell_ctrl_t;

endpackage

// ===== design/flac_lpc_reconstruct.sv =====
// A result sits in the output register from the cycle after its item is accepted.
// Throughput: one item per cycle (s_tready high); the recursion closes via the head
//   cell's partial sum, one shift, one add and one 16x16 multiply in each cell.
// Reset: history, partial sums and coefficients clear; order 2, shift 0; ready at once.
// After any configuration write the input stalls through the load, align and replay
//   states while the cells realign their coefficients and replay the stored history.
module flac_lpc_reconstruct #(
  parameter int MAX_ORDER = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [flpc_pkg::DATA_W-1:0]        s_tdata,   // [31:0] value
  input  logic                               s_tuser,   // [0] kind (1 = residual)
  input  logic                               s_tlast,   // end_of_block
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [flpc_pkg::DATA_W-1:0]        m_tdata,   // [31:0] sample
  output logic                               m_tlast,   // last
  // configuration
  input  logic                               cfg_we,
  input  logic [flpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [flpc_pkg::CFG_W-1:0]         cfg_data
);
  import flpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_ORDER + 1);
  localparam int OW    = (CNT_W > REG_W) ? CNT_W : REG_W;

  // Sequencer states
  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_ALIGN  = 2'd2;
  localparam logic [1:0] ST_REPLAY = 2'd3;

  logic [CFG_W-1:0]         coef_group [NUM_GROUPS];
  logic [REG_W-1:0]         predictor_order;
  logic [REG_W-1:0]         quant_shift;

  logic [1:0]               state;
  logic [CNT_W-1:0]         cnt;
  logic [OW-1:0]            order_ext;
  logic [OW-1:0]            order_c;

  cell_ctrl_t               ctrl;
  logic signed [COEF_W-1:0] coef_chain [MAX_ORDER+1];
  logic signed [COEF_W-1:0] coef_load  [MAX_ORDER];
  logic signed [HIST_W-1:0] hist_chain [MAX_ORDER+1];
  logic signed [DATA_W-1:0] psum_chain [MAX_ORDER+1];
  logic signed [HIST_W-1:0] push_sample;

  logic                     accept;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] pred;
  logic signed [DATA_W-1:0] recon;
  logic signed [HIST_W-1:0] warm_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        coef_group[g] <= '0;
      end
      predictor_order <= ORDER_RESET;
      quant_shift     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_GROUP_0:    coef_group[0]   <= cfg_data;
        REG_COEF_GROUP_1:    coef_group[1]   <= cfg_data;
        REG_COEF_GROUP_2:    coef_group[2]   <= cfg_data;
        REG_COEF_GROUP_3:    coef_group[3]   <= cfg_data;
        REG_PREDICTOR_ORDER: predictor_order <= cfg_data[REG_W-1:0];
        REG_QUANT_SHIFT:     quant_shift     <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the order to 2 .. MAX_ORDER
  assign order_ext = OW'(predictor_order);
  always_comb begin
    if (order_ext < OW'(2)) begin
      order_c = OW'(2);
    end else if (order_ext > OW'(MAX_ORDER)) begin
      order_c = OW'(MAX_ORDER);
    end else begin
      order_c = order_ext;
    end
  end

  // Sequencer: run, or rebuild partial sums after a configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
    end else if (cfg_we) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_RUN: ;
        ST_LOAD: begin
          state <= ST_ALIGN;
          cnt   <= CNT_W'(OW'(MAX_ORDER) - order_c);
        end
        ST_ALIGN: begin
          if (cnt == '0) begin
            state <= ST_REPLAY;
            cnt   <= CNT_W'(MAX_ORDER);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_REPLAY: begin
          if (cnt == '0) begin
            state <= ST_RUN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  assign s_tready = (state == ST_RUN) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Prediction from the head cell, then reconstruction
  assign in_value = $signed(s_tdata);
  assign pred     = psum_chain[0] >>> quant_shift;
  assign recon    = pred + in_value;

  // Warm-up sample saturated to 16 bits for the history
  always_comb begin
    if (in_value > $signed(DATA_W'(32767))) begin
      warm_sat = 16'sh7fff;
    end else if (in_value < -$signed(DATA_W'(32768))) begin
      warm_sat = 16'sh8000;
    end else begin
      warm_sat = in_value[HIST_W-1:0];
    end
  end

  // Cell control and pushed sample; replay rotates the oldest tap back in
  always_comb begin
    ctrl.clear      = (state == ST_LOAD) && !cfg_we;
    ctrl.shift_coef = (state == ST_ALIGN) && (cnt != '0) && !cfg_we;
    ctrl.push       = accept || ((state == ST_REPLAY) && (cnt != '0) && !cfg_we);
    if (state == ST_REPLAY) begin
      push_sample = hist_chain[MAX_ORDER];
    end else if (s_tuser) begin
      push_sample = recon[HIST_W-1:0];
    end else begin
      push_sample = warm_sat;
    end
  end

  assign coef_chain[MAX_ORDER] = '0;
  assign psum_chain[MAX_ORDER] = '0;
  assign hist_chain[0]         = push_sample;

  // Chain of cells, cell i holds the tap of age i+1
  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
    localparam int IDX = MAX_ORDER - 1 - i;
    if (IDX < NUM_COEFS) begin : g_coef
      localparam int GRP = IDX / COEFS_PER_GROUP;
      localparam int SUB = IDX % COEFS_PER_GROUP;
      assign coef_load[i] = $signed(coef_group[GRP][SUB*COEF_W +: COEF_W]);
    end else begin : g_zero
      assign coef_load[i] = '0;
    end

    flpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .coef_load (coef_load[i]),
      .coef_in   (coef_chain[i+1]),
      .coef_out  (coef_chain[i]),
      .sample    (push_sample),
      .hist_in   (hist_chain[i]),
      .hist_out  (hist_chain[i+1]),
      .psum_in   (psum_chain[i+1]),
      .psum_out  (psum_chain[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= s_tuser ? recon : in_value;
      m_tlast <= s_tlast;
    end
  end

endmodule

// ===== design/flpc_cell.sv =====
module flpc_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  flpc_pkg::cell_ctrl_t                ctrl,
  input  logic signed [flpc_pkg::COEF_W-1:0]  coef_load,
  input  logic signed [flpc_pkg::COEF_W-1:0]  coef_in,
  output logic signed [flpc_pkg::COEF_W-1:0]  coef_out,
  input  logic signed [flpc_pkg::HIST_W-1:0]  sample,
  input  logic signed [flpc_pkg::HIST_W-1:0]  hist_in,
  output logic signed [flpc_pkg::HIST_W-1:0]  hist_out,
  input  logic signed [flpc_pkg::DATA_W-1:0]  psum_in,
  output logic signed [flpc_pkg::DATA_W-1:0]  psum_out
);
  import flpc_pkg::*;

  logic signed [COEF_W-1:0] coef;
  logic signed [HIST_W-1:0] hist;
  logic signed [DATA_W-1:0] psum;
  logic signed [DATA_W-1:0] prod;

  // 16x16 signed product of this tap with the sample being pushed
  assign prod = coef * sample;

  // Coefficient, history tap and transposed partial sum
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      hist <= '0;
      psum <= '0;
    end else if (ctrl.clear) begin
      coef <= coef_load;
      psum <= '0;
    end else if (ctrl.shift_coef) begin
      coef <= coef_in;
    end else if (ctrl.push) begin
      hist <= hist_in;
      psum <= psum_in + prod;
    end
  end

  assign coef_out = coef;
  assign hist_out = hist;
  assign psum_out = psum;

endmodule
